/* rtl/ssd_pkg.sv */
`timescale 1ns / 1ps

package ssd_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int CW    = 32;            // coordinate width
   localparam int NCOORD = 12;
   localparam int IN_W  = NCOORD * CW;   // request word width
   localparam int DW    = CW + 1;        // difference width
   localparam int WW    = 140;           // exact width of dot products and their products
   localparam int PFRAC = 32;            // fraction bits of sc and tc
   localparam int QW    = PFRAC + 1;     // sc and tc hold 0 .. 2^32
   localparam int PW    = 70;            // width of one component of dP
   localparam int RW    = 47;            // square root bits
   localparam int OW    = 40;            // distance width
   localparam int OUT_W = 48;            // response word width, whole bytes
   localparam int DIV_STAGES = 8;
   localparam int DIV_STEPS  = PFRAC / DIV_STAGES;
   localparam int SQ_STEPS   = 6;
   localparam int SQ_STAGES  = (RW + SQ_STEPS - 1) / SQ_STEPS;
   localparam int HW    = 34;            // half width of a split product operand
   localparam int PPW   = 2 * (HW + 1);  // width of one partial product
   localparam logic [OW-1:0] DIST_MAX = {OW{1'b1}};

   typedef logic signed [DW-1:0] diff_type;
   typedef logic signed [WW-1:0] wide_type;
   typedef logic signed [PW-1:0] comp_type;
   typedef logic signed [PPW-1:0] pprod_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
      diff_type z;
   } vec3_type;

   typedef struct packed {
      vec3_type u;
      vec3_type v;
      vec3_type w;
   } geo_type;

   // Handed from the dot-product section to the clamp and divide section.
   typedef struct packed {
      wide_type d_det;
      wide_type s_num;
      wide_type t_num;
      wide_type a;
      wide_type b;
      wide_type c;
      wide_type d;
      wide_type e;
      geo_type  geo;
   } dots_type;

   // Handed from the divide section to the distance section.
   typedef struct packed {
      logic [QW-1:0] sc;
      logic [QW-1:0] tc;
      geo_type       geo;
   } params_type;

   // Four partial products of two operands that fit in 2*HW signed bits.
   typedef struct packed {
      pprod_type hh;
      pprod_type hl;
      pprod_type lh;
      pprod_type ll;
   } part_type;

   // Splits each operand into a signed upper half and an unsigned lower half.
   function automatic part_type part_mul(input wide_type x, input wide_type y);
      part_type          r;
      logic signed [HW:0] xh;
      logic signed [HW:0] xl;
      logic signed [HW:0] yh;
      logic signed [HW:0] yl;
      begin
         xh   = {x[2*HW-1], x[2*HW-1:HW]};
         xl   = {1'b0, x[HW-1:0]};
         yh   = {y[2*HW-1], y[2*HW-1:HW]};
         yl   = {1'b0, y[HW-1:0]};
         r.hh = xh * yh;
         r.hl = xh * yl;
         r.lh = xl * yh;
         r.ll = xl * yl;
         return r;
      end
   endfunction

   function automatic wide_type part_sum(input part_type p);
      begin
         return (WW'(p.hh) <<< (2 * HW)) + ((WW'(p.hl) + WW'(p.lh)) <<< HW) + WW'(p.ll);
      end
   endfunction

endpackage

/* rtl/ssd_dot.sv */
`timescale 1ns / 1ps

// Differences, the five dot products, their cross products and the
// determinant with both raw numerators: five register stages. The cross
// products are formed from partial products in one stage and summed in the next.
module ssd_dot (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ce,
   input  logic                  in_valid,
   input  logic [ssd_pkg::IN_W-1:0] in_data,
   output logic                  out_valid,
   output ssd_pkg::dots_type     out_dots
);
   import ssd_pkg::*;

   function automatic diff_type coord_diff(input logic [IN_W-1:0] data, input int hi,
                                           input int lo);
      logic signed [CW-1:0] ph;
      logic signed [CW-1:0] pl;
      begin
         ph = data[hi*CW +: CW];
         pl = data[lo*CW +: CW];
         return DW'(ph) - DW'(pl);
      end
   endfunction

   function automatic wide_type dot3(input vec3_type p, input vec3_type q);
      logic signed [2*DW-1:0] m0;
      logic signed [2*DW-1:0] m1;
      logic signed [2*DW-1:0] m2;
      begin
         m0 = p.x * q.x;
         m1 = p.y * q.y;
         m2 = p.z * q.z;
         return WW'(m0) + WW'(m1) + WW'(m2);
      end
   endfunction

   logic [4:0] vld_ff;
   geo_type    geo1_ff, geo2_ff, geo3_ff, geo4_ff, geo5_ff;
   geo_type    geo_in;
   wide_type   a2_ff, b2_ff, c2_ff, d2_ff, e2_ff;
   wide_type   a3_ff, b3_ff, c3_ff, d3_ff, e3_ff;
   wide_type   a4_ff, b4_ff, c4_ff, d4_ff, e4_ff;
   part_type   pac_ff, pbb_ff, pbe_ff, pcd_ff, pae_ff, pbd_ff;
   wide_type   ac_ff, bb_ff, be_ff, cd_ff, ae_ff, bd_ff;
   dots_type   dots_ff;

   always_comb begin
      geo_in.u.x = coord_diff(in_data, 3, 0);
      geo_in.u.y = coord_diff(in_data, 4, 1);
      geo_in.u.z = coord_diff(in_data, 5, 2);
      geo_in.v.x = coord_diff(in_data, 9, 6);
      geo_in.v.y = coord_diff(in_data, 10, 7);
      geo_in.v.z = coord_diff(in_data, 11, 8);
      geo_in.w.x = coord_diff(in_data, 0, 6);
      geo_in.w.y = coord_diff(in_data, 1, 7);
      geo_in.w.z = coord_diff(in_data, 2, 8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         geo1_ff <= geo_in;
         a2_ff   <= dot3(geo1_ff.u, geo1_ff.u);
         b2_ff   <= dot3(geo1_ff.u, geo1_ff.v);
         c2_ff   <= dot3(geo1_ff.v, geo1_ff.v);
         d2_ff   <= dot3(geo1_ff.u, geo1_ff.w);
         e2_ff   <= dot3(geo1_ff.v, geo1_ff.w);
         geo2_ff <= geo1_ff;
         pac_ff  <= part_mul(a2_ff, c2_ff);
         pbb_ff  <= part_mul(b2_ff, b2_ff);
         pbe_ff  <= part_mul(b2_ff, e2_ff);
         pcd_ff  <= part_mul(c2_ff, d2_ff);
         pae_ff  <= part_mul(a2_ff, e2_ff);
         pbd_ff  <= part_mul(b2_ff, d2_ff);
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         c3_ff   <= c2_ff;
         d3_ff   <= d2_ff;
         e3_ff   <= e2_ff;
         geo3_ff <= geo2_ff;
         ac_ff   <= part_sum(pac_ff);
         bb_ff   <= part_sum(pbb_ff);
         be_ff   <= part_sum(pbe_ff);
         cd_ff   <= part_sum(pcd_ff);
         ae_ff   <= part_sum(pae_ff);
         bd_ff   <= part_sum(pbd_ff);
         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff;
         c4_ff   <= c3_ff;
         d4_ff   <= d3_ff;
         e4_ff   <= e3_ff;
         geo4_ff <= geo3_ff;
         dots_ff.d_det <= ac_ff - bb_ff;
         dots_ff.s_num <= be_ff - cd_ff;
         dots_ff.t_num <= ae_ff - bd_ff;
         dots_ff.a     <= a4_ff;
         dots_ff.b     <= b4_ff;
         dots_ff.c     <= c4_ff;
         dots_ff.d     <= d4_ff;
         dots_ff.e     <= e4_ff;
         dots_ff.geo   <= geo4_ff;
         geo5_ff       <= geo4_ff;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_dots  = dots_ff;

   // The last stage carries the geometry of the same item in two places.
   a_geo_aligned: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (dots_ff.geo == geo5_ff))
      else $error("geometry misaligned in dot stages");

endmodule

/* rtl/ssd_div.sv */
`timescale 1ns / 1ps

// Clamps the closest-point parameters, then divides both numerators by
// their denominators, DIV_STEPS quotient bits per stage.
module ssd_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                ce,
   input  logic                in_valid,
   input  ssd_pkg::dots_type   in_dots,
   output logic                out_valid,
   output ssd_pkg::params_type out_params
);
   import ssd_pkg::*;

   typedef struct packed {
      wide_type      rem;
      wide_type      den;
      logic [QW-1:0] q;
      logic          run;
   } divs_type;

   function automatic divs_type div_prep(input wide_type num, input wide_type den);
      divs_type r;
      begin
         r.rem = num;
         r.den = den;
         r.q   = '0;
         r.run = 1'b0;
         if (num <= 0 || den <= 0) begin
            r.q = '0;
         end else if (num >= den) begin
            r.q = QW'(1) << PFRAC;
         end else begin
            r.run = 1'b1;
         end
         return r;
      end
   endfunction

   function automatic divs_type div_step(input divs_type x);
      divs_type r;
      begin
         r = x;
         if (x.run) begin
            r.rem = x.rem <<< 1;
            r.q   = x.q << 1;
            if (r.rem >= x.den) begin
               r.q[0] = 1'b1;
               r.rem  = r.rem - x.den;
            end
         end
         return r;
      end
   endfunction

   localparam int NS = DIV_STAGES + 1;

   wide_type sn_in, sd_in, tn_in, td_in, nd, tb;
   wide_type sn_ff, sd_ff, tn_ff, td_ff;
   geo_type  geoc_ff;
   logic [NS:0] vld_ff;
   divs_type ds_ff [NS];
   divs_type dt_ff [NS];
   geo_type  geo_ff [NS];

   always_comb begin
      nd = -in_dots.d;
      tb = nd + in_dots.b;
      if (in_dots.d_det <= 0) begin
         sn_in = '0;
         sd_in = WW'(1);
         tn_in = in_dots.e;
         td_in = in_dots.c;
      end else begin
         sn_in = in_dots.s_num;
         sd_in = in_dots.d_det;
         tn_in = in_dots.t_num;
         td_in = in_dots.d_det;
         if (in_dots.s_num < 0) begin
            sn_in = '0;
            tn_in = in_dots.e;
            td_in = in_dots.c;
         end else if (in_dots.s_num > in_dots.d_det) begin
            sn_in = in_dots.d_det;
            tn_in = in_dots.e + in_dots.b;
            td_in = in_dots.c;
         end
      end
      if (tn_in < 0) begin
         tn_in = '0;
         if (nd < 0) begin
            sn_in = '0;
         end else if (nd > in_dots.a) begin
            sn_in = sd_in;
         end else begin
            sn_in = nd;
            sd_in = in_dots.a;
         end
      end else if (tn_in > td_in) begin
         tn_in = td_in;
         if (tb < 0) begin
            sn_in = '0;
         end else if (tb > in_dots.a) begin
            sn_in = sd_in;
         end else begin
            sn_in = tb;
            sd_in = in_dots.a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sn_ff     <= sn_in;
         sd_ff     <= sd_in;
         tn_ff     <= tn_in;
         td_ff     <= td_in;
         geoc_ff   <= in_dots.geo;
         ds_ff[0]  <= div_prep(sn_ff, sd_ff);
         dt_ff[0]  <= div_prep(tn_ff, td_ff);
         geo_ff[0] <= geoc_ff;
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_div
      divs_type ds_in, dt_in;
      always_comb begin
         ds_in = ds_ff[s-1];
         dt_in = dt_ff[s-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            ds_in = div_step(ds_in);
            dt_in = div_step(dt_in);
         end
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            ds_ff[s]  <= ds_in;
            dt_ff[s]  <= dt_in;
            geo_ff[s] <= geo_ff[s-1];
         end
      end
   end

   assign out_valid          = vld_ff[NS];
   assign out_params.sc      = ds_ff[NS-1].q;
   assign out_params.tc      = dt_ff[NS-1].q;
   assign out_params.geo     = geo_ff[NS-1];

   // A division still running keeps its partial remainder below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NS] && ds_ff[NS-1].run) |-> (ds_ff[NS-1].rem < ds_ff[NS-1].den))
      else $error("sc remainder out of range");

   a_param_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] |-> (out_params.sc <= (QW'(1) << PFRAC) && out_params.tc <= (QW'(1) << PFRAC)))
      else $error("parameter above one");

endmodule

/* rtl/ssd_dist.sv */
`timescale 1ns / 1ps

// Difference vector, sum of squares and a digit-by-digit square root,
// SQ_STEPS root bits per stage, then saturation into the output register.
module ssd_dist #(
   parameter int COORD_FRAC_BITS = ssd_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ce,
   input  logic                   in_valid,
   input  ssd_pkg::params_type    in_params,
   output logic                   out_valid,
   output logic [ssd_pkg::OW-1:0] out_distance
);
   import ssd_pkg::*;

   localparam int SHIFT = 2 * COORD_FRAC_BITS + PFRAC;
   localparam int NV    = SQ_STAGES + 4;

   typedef struct packed {
      logic [WW-1:0] rem;
      logic [RW-1:0] root;
   } sqs_type;

   function automatic comp_type dp_comp(input diff_type w, input diff_type u,
                                        input diff_type v, input logic [QW-1:0] sc,
                                        input logic [QW-1:0] tc);
      logic signed [DW+QW:0] us;
      logic signed [DW+QW:0] vt;
      begin
         us = u * $signed({1'b0, sc});
         vt = v * $signed({1'b0, tc});
         return (PW'(w) <<< PFRAC) + PW'(us) - PW'(vt);
      end
   endfunction

   function automatic sqs_type sq_step(input sqs_type x, input int bitn);
      sqs_type       r;
      logic [WW-1:0] trial;
      begin
         r = x;
         if (bitn >= 0) begin
            trial = (WW'(x.root) << (bitn + 1)) | (WW'(1) << (2 * bitn));
            if (trial <= x.rem) begin
               r.rem        = x.rem - trial;
               r.root[bitn] = 1'b1;
            end
         end
         return r;
      end
   endfunction

   logic [NV:0]   vld_ff;
   comp_type      px_ff, py_ff, pz_ff;
   part_type      rx_ff, ry_ff, rz_ff;
   wide_type      qx_ff, qy_ff, qz_ff;
   wide_type      sum;
   sqs_type       sq_ff [SQ_STAGES+1];
   logic [OW-1:0] dist_ff;

   assign sum = qx_ff + qy_ff + qz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[NV-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         px_ff <= dp_comp(in_params.geo.w.x, in_params.geo.u.x, in_params.geo.v.x,
                          in_params.sc, in_params.tc);
         py_ff <= dp_comp(in_params.geo.w.y, in_params.geo.u.y, in_params.geo.v.y,
                          in_params.sc, in_params.tc);
         pz_ff <= dp_comp(in_params.geo.w.z, in_params.geo.u.z, in_params.geo.v.z,
                          in_params.sc, in_params.tc);
         rx_ff <= part_mul(WW'(px_ff), WW'(px_ff));
         ry_ff <= part_mul(WW'(py_ff), WW'(py_ff));
         rz_ff <= part_mul(WW'(pz_ff), WW'(pz_ff));
         qx_ff <= part_sum(rx_ff);
         qy_ff <= part_sum(ry_ff);
         qz_ff <= part_sum(rz_ff);
         sq_ff[0].rem  <= WW'(sum) >> SHIFT;
         sq_ff[0].root <= '0;
      end
   end

   for (genvar s = 1; s <= SQ_STAGES; s++) begin : g_sq
      sqs_type sq_in;
      always_comb begin
         sq_in = sq_ff[s-1];
         for (int j = 0; j < SQ_STEPS; j++) begin
            sq_in = sq_step(sq_in, RW - 1 - ((s - 1) * SQ_STEPS + j));
         end
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            sq_ff[s] <= sq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         if (sq_ff[SQ_STAGES].root > RW'(DIST_MAX)) begin
            dist_ff <= DIST_MAX;
         end else begin
            dist_ff <= sq_ff[SQ_STAGES].root[OW-1:0];
         end
      end
   end

   assign out_valid    = vld_ff[NV];
   assign out_distance = dist_ff;

   // The remainder never exceeds twice the root found so far.
   a_sq_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NV-1] |-> (sq_ff[SQ_STAGES].rem <= (WW'(sq_ff[SQ_STAGES].root) << 1)))
      else $error("square root remainder too large");

endmodule

/* rtl/segment_segment_distance_3d.sv */
`timescale 1ns / 1ps

// Shortest distance between two 3D segments. A request word carries the
// four endpoints as signed fixed point with COORD_FRAC_BITS fraction bits;
// the response word carries the distance as unsigned Q24.16, saturating at
// the largest 40-bit value. Degenerate and parallel segments are handled
// exactly: no tolerance is used, every intermediate value is an exact
// integer. The block takes one pair in every clock cycle while the response
// is not stalled and returns the results in order, through five stages of dot
// products and determinant, one clamp stage, one divider set-up stage and
// eight divider stages of four quotient bits each, four stages forming the
// sum of squares, eight square root stages of up to six bits each and the
// output register. The wide products are built from partial products in one
// stage and summed in the next. The whole pipeline advances together, so a
// stalled response holds every stage and nothing is dropped or repeated.
module segment_segment_distance_3d #(
   parameter int COORD_FRAC_BITS = ssd_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0 up: seg1_start_x, seg1_start_y, seg1_start_z,
   // seg1_end_x, seg1_end_y, seg1_end_z, seg2_start_x, seg2_start_y,
   // seg2_start_z, seg2_end_x, seg2_end_y, seg2_end_z (32 bits each).
   input  logic [ssd_pkg::IN_W-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0 up: distance (40 bits), then zero padding.
   output logic [ssd_pkg::OUT_W-1:0] rsp_tdata
);
   import ssd_pkg::*;

   logic          ce;
   logic          dot_vld, div_vld;
   dots_type      dots;
   params_type    params;
   logic [OW-1:0] distance;
   logic [5:0]    inflight_ff;

   // Every stage moves when the output register is empty or being read.
   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   ssd_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (dot_vld),
      .out_dots  (dots)
   );

   ssd_div u_div (
      .clock      (clock),
      .reset      (reset),
      .ce         (ce),
      .in_valid   (dot_vld),
      .in_dots    (dots),
      .out_valid  (div_vld),
      .out_params (params)
   );

   ssd_dist #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .ce           (ce),
      .in_valid     (div_vld),
      .in_params    (params),
      .out_valid    (rsp_tvalid),
      .out_distance (distance)
   );

   assign rsp_tdata = {(OUT_W - OW)'(0), distance};

   // Words accepted but not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + 6'(req_tvalid && req_tready)
                                    - 6'(rsp_tvalid && rsp_tready);
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_inflight_max: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 6'd28)
      else $error("more words in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == 6'd0) |-> !rsp_tvalid)
      else $error("response without a request");

endmodule
